[src/fcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

  // request actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  // register offsets
  localparam logic [7:0] REG_LATCH   = 8'h40;
  localparam logic [7:0] REG_COMMAND = 8'h48;
  localparam logic [7:0] REG_TRACK   = 8'h49;
  localparam logic [7:0] REG_SECTOR  = 8'h4A;
  localparam logic [7:0] REG_DATA    = 8'h4B;

  // commands and status
  localparam logic [7:0] CMD_SEEK        = 8'h17;
  localparam logic [7:0] CMD_READ_SECTOR = 8'h80;
  localparam logic [7:0] CMD_GROUP_MASK  = 8'hF0;
  localparam logic [7:0] CMD_GROUP_READ  = 8'h80;
  localparam logic [7:0] STATUS_BUSY     = 8'h02;
  localparam logic [7:0] STATUS_KEEP     = 8'h01;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } fcr_state_t;

  // sequencer to datapath control
  typedef struct packed {
    logic busy;
    logic exec;
    logic clear_we;
  } fcr_ctl_t;

endpackage

`default_nettype wire

[src/floppy_controller_registers.sv]
`timescale 1ns / 1ps
`default_nettype none
// Result path: an accepted request moves the sequencer into its execute state,
// and done and the result payload are registered from that state.
// No new request is taken while the sequencer executes; busy is high there.
// The receiver cannot stall; done lasts one cycle.
// Reset: registers clear at once; the sector buffer is then zeroed by a pass
// over every buffer address, during which busy is high.
module floppy_controller_registers
  import fcr_pkg::*;
#(
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] action,
  input  wire logic [7:0] reg_offset,
  input  wire logic [7:0] write_data,
  input  wire logic [7:0] fill_index,
  output logic            done,
  output logic      [7:0] read_data,
  output logic            read_driven,
  output logic            nmi_pulse,
  output logic            host_request,
  output logic      [7:0] request_command,
  output logic      [7:0] request_latch,
  output logic      [7:0] request_track,
  output logic      [7:0] request_sector
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int FW = ((PW > 8) ? PW : 8) + 1;
  localparam logic [PW-1:0] LAST_ADDR = PW'(BUFFER_BYTES - 1);
  localparam logic [FW-1:0] DEPTH_F   = FW'(BUFFER_BYTES);
  localparam logic [7:0]    LAST_FILL = 8'((BUFFER_BYTES - 1) % 256);

  fcr_ctl_t ctl;
  logic [PW-1:0] clear_addr;
  logic accept;

  // captured request
  logic [1:0] act_q;
  logic [7:0] reg_q;
  logic [7:0] data_q;
  logic [7:0] fidx_q;

  // controller registers
  logic [7:0]    drive_latch;
  logic [7:0]    status_bits;
  logic [7:0]    track_number;
  logic [7:0]    sector_number;
  logic [PW-1:0] buffer_pointer;

  // buffer port signals
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [FW-1:0] fill_ext;
  logic [PW-1:0] fill_addr;
  logic [PW-1:0] ptr_step;
  logic          ptr_wrap;
  logic          data_access;

  assign accept = start && !busy;
  assign busy   = ctl.busy;

  fcr_seq #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .ctl       (ctl),
    .clear_addr(clear_addr)
  );

  fcr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // capture request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= action;
      reg_q  <= reg_offset;
      data_q <= write_data;
      fidx_q <= fill_index;
    end
  end

  // read issued at accept: byte 0 for any write (a seek command uses it), else the pointer
  assign ram_raddr = (action == ACT_WRITE) ? '0 : buffer_pointer;

  // fill position folded into the buffer
  assign fill_ext  = FW'(fidx_q);
  always_comb begin
    if (fill_ext >= DEPTH_F) begin
      fill_addr = PW'(fill_ext - DEPTH_F);
    end else begin
      fill_addr = PW'(fill_ext);
    end
  end

  // pointer step with wrap
  assign ptr_wrap = (buffer_pointer == LAST_ADDR);
  assign ptr_step = ptr_wrap ? '0 : buffer_pointer + PW'(1);
  assign data_access = ctl.exec && (reg_q == REG_DATA) &&
                       ((act_q == ACT_WRITE) || (act_q == ACT_READ));

  // buffer write: clearing pass, data write or host fill
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = buffer_pointer;
    ram_wdata = data_q;
    if (ctl.clear_we) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else if (ctl.exec && (act_q == ACT_WRITE) && (reg_q == REG_DATA)) begin
      ram_we = 1'b1;
    end else if (ctl.exec && (act_q == ACT_FILL)) begin
      ram_we    = 1'b1;
      ram_waddr = fill_addr;
    end
  end

  // register updates
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_latch    <= '0;
      status_bits    <= '0;
      track_number   <= '0;
      sector_number  <= '0;
      buffer_pointer <= '0;
    end else if (ctl.exec) begin
      if (data_access) begin
        buffer_pointer <= ptr_step;
      end
      case (act_q)
        ACT_WRITE: begin
          case (reg_q)
            REG_LATCH:  drive_latch   <= data_q;
            REG_TRACK:  track_number  <= data_q;
            REG_SECTOR: sector_number <= data_q;
            REG_COMMAND: begin
              status_bits <= ((data_q & CMD_GROUP_MASK) == CMD_GROUP_READ) ?
                             STATUS_BUSY : '0;
              buffer_pointer <= '0;
              if (data_q == CMD_SEEK) begin
                track_number <= ram_rdata;
              end
            end
            default: ;
          endcase
        end
        ACT_READ: begin
          if (reg_q == REG_COMMAND) begin
            status_bits <= status_bits & STATUS_KEEP;
          end
        end
        ACT_FILL: begin
          if (fidx_q == LAST_FILL) begin
            buffer_pointer <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.exec;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      read_data       <= '0;
      read_driven     <= 1'b0;
      nmi_pulse       <= data_access && ptr_wrap && drive_latch[7];
      host_request    <= 1'b0;
      request_command <= '0;
      request_latch   <= '0;
      request_track   <= '0;
      request_sector  <= '0;
      if (act_q == ACT_READ) begin
        if (reg_q == REG_COMMAND) begin
          read_data   <= status_bits;
          read_driven <= 1'b1;
        end else if (reg_q == REG_DATA) begin
          read_data   <= ram_rdata;
          read_driven <= 1'b1;
        end
      end
      if ((act_q == ACT_WRITE) && (reg_q == REG_COMMAND) &&
          (data_q == CMD_READ_SECTOR)) begin
        host_request    <= 1'b1;
        request_command <= data_q;
        request_latch   <= drive_latch;
        request_track   <= track_number;
        request_sector  <= sector_number;
      end
    end
  end

endmodule

`default_nettype wire

[src/fcr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module fcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/fcr_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module fcr_seq
  import fcr_pkg::*;
#(
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            accept,
  output fcr_ctl_t                             ctl,
  output logic      [$clog2(BUFFER_BYTES)-1:0] clear_addr
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam logic [PW-1:0] LAST_ADDR = PW'(BUFFER_BYTES - 1);

  fcr_state_t state, state_next;
  logic [PW-1:0] clear_addr_next;

  // state and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state      <= state_next;
      clear_addr <= clear_addr_next;
    end
  end

  // next state
  always_comb begin
    state_next      = state;
    clear_addr_next = clear_addr;
    case (state)
      ST_CLEAR: begin
        clear_addr_next = clear_addr + PW'(1);
        if (clear_addr == LAST_ADDR) begin
          state_next      = ST_IDLE;
          clear_addr_next = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next      = ST_CLEAR;
        clear_addr_next = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    case (state)
      ST_CLEAR: begin
        ctl.busy     = 1'b1;
        ctl.clear_we = 1'b1;
      end
      ST_IDLE: begin
        ctl = '0;
      end
      ST_EXEC: begin
        ctl.busy = 1'b1;
        ctl.exec = 1'b1;
      end
      default: begin
        ctl.busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[tb/floppy_controller_registers_test.sv]
`timescale 1ns / 1ps

module floppy_controller_registers_test;
  import fcr_pkg::*;

  localparam int BUFFER_BYTES = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1400;
  localparam logic [7:0] MAPPED_REGS [5] = '{REG_LATCH, REG_COMMAND, REG_TRACK,
                                              REG_SECTOR, REG_DATA};

  // one reply of the controller, field for field
  typedef struct {
    logic [7:0] read_data;
    logic       read_driven;
    logic       nmi_pulse;
    logic       host_request;
    logic [7:0] request_command;
    logic [7:0] request_latch;
    logic [7:0] request_track;
    logic [7:0] request_sector;
  } fcr_reply_t;

  // Register file predictor plus the queue of replies still owed
  class controller_model;
    logic [7:0] latch_q;
    logic [7:0] status_q;
    logic [7:0] track_q;
    logic [7:0] sector_q;
    int         pointer_q;
    logic [7:0] sector_bytes [BUFFER_BYTES];
    fcr_reply_t expected_replies [$];
    int         mismatches;

    function new();
      latch_q = '0;
      status_q = '0;
      track_q = '0;
      sector_q = '0;
      pointer_q = 0;
      mismatches = 0;
      foreach (sector_bytes[i]) sector_bytes[i] = '0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // step the byte pointer; NMI when it wraps with latch bit 7 set
    function logic advance_pointer();
      logic nmi;
      nmi = 1'b0;
      pointer_q = pointer_q + 1;
      if (pointer_q >= BUFFER_BYTES) begin
        pointer_q = 0;
        nmi = latch_q[7];
      end
      return nmi;
    endfunction

    // predict the reply of an accepted request and update the register copy
    function void note_request(logic [1:0] act, logic [7:0] offset, logic [7:0] wdata,
                               logic [7:0] findex);
      fcr_reply_t r;
      r = '{default: '0};
      case (act)
        ACT_WRITE: begin
          case (offset)
            REG_LATCH: latch_q = wdata;
            REG_COMMAND: begin
              status_q = ((wdata & CMD_GROUP_MASK) == CMD_GROUP_READ) ? STATUS_BUSY : 8'h00;
              pointer_q = 0;
              if (wdata == CMD_SEEK) track_q = sector_bytes[0];
              if (wdata == CMD_READ_SECTOR) begin
                r.host_request = 1'b1;
                r.request_command = wdata;
                r.request_latch = latch_q;
                r.request_track = track_q;
                r.request_sector = sector_q;
              end
            end
            REG_TRACK: track_q = wdata;
            REG_SECTOR: sector_q = wdata;
            REG_DATA: begin
              sector_bytes[pointer_q] = wdata;
              r.nmi_pulse = advance_pointer();
            end
            default: ;
          endcase
        end
        ACT_READ: begin
          if (offset == REG_COMMAND) begin
            r.read_data = status_q;
            r.read_driven = 1'b1;
            status_q = status_q & STATUS_KEEP;
          end else if (offset == REG_DATA) begin
            r.read_data = sector_bytes[pointer_q];
            r.read_driven = 1'b1;
            r.nmi_pulse = advance_pointer();
          end
        end
        ACT_FILL: begin
          sector_bytes[int'(findex) % BUFFER_BYTES] = wdata;
          if (findex == 8'((BUFFER_BYTES - 1) & 8'hFF)) pointer_q = 0;
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // compare one reply against the oldest expectation
    function void check_result(fcr_reply_t got);
      fcr_reply_t want;
      if (expected_replies.size() == 0) begin
        $error("reply with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("read_driven", want.read_driven, got.read_driven);
      compare_field("nmi_pulse", want.nmi_pulse, got.nmi_pulse);
      compare_field("host_request", want.host_request, got.host_request);
      compare_field("request_command", want.request_command, got.request_command);
      compare_field("request_latch", want.request_latch, got.request_latch);
      compare_field("request_track", want.request_track, got.request_track);
      compare_field("request_sector", want.request_sector, got.request_sector);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] action;
  logic [7:0] reg_offset;
  logic [7:0] write_data;
  logic [7:0] fill_index;
  logic       done;
  logic [7:0] read_data;
  logic       read_driven;
  logic       nmi_pulse;
  logic       host_request;
  logic [7:0] request_command;
  logic [7:0] request_latch;
  logic [7:0] request_track;
  logic [7:0] request_sector;

  controller_model model = new();
  int sender_idle_pct;
  int requests_sent;
  int cycle_count;

  floppy_controller_registers #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .reg_offset(reg_offset),
    .write_data(write_data),
    .fill_index(fill_index),
    .done(done),
    .read_data(read_data),
    .read_driven(read_driven),
    .nmi_pulse(nmi_pulse),
    .host_request(host_request),
    .request_command(request_command),
    .request_latch(request_latch),
    .request_track(request_track),
    .request_sector(request_sector)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // replies are sampled at the edge that ends their strobe cycle
  always @(posedge clk) begin
    fcr_reply_t got;
    if (!rst && done) begin
      got.read_data = read_data;
      got.read_driven = read_driven;
      got.nmi_pulse = nmi_pulse;
      got.host_request = host_request;
      got.request_command = request_command;
      got.request_latch = request_latch;
      got.request_track = request_track;
      got.request_sector = request_sector;
      model.check_result(got);
    end
  end

  // present one request, hold it until accepted, then maybe idle
  task automatic issue(input logic [1:0] act, input logic [7:0] offset,
                       input logic [7:0] wdata, input logic [7:0] findex);
    start <= 1'b1;
    action <= act;
    reg_offset <= offset;
    write_data <= wdata;
    fill_index <= findex;
    do @(posedge clk); while (busy);
    model.note_request(act, offset, wdata, findex);
    requests_sent++;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // stop sending until every owed reply has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
  endtask

  initial begin
    int phase;
    int count;
    int first;
    logic [7:0] cmd;

    cycle_count <= 0;
    rst <= 1'b1;
    start <= 1'b0;
    action <= ACT_WRITE;
    reg_offset <= '0;
    write_data <= '0;
    fill_index <= '0;
    requests_sent = 0;
    sender_idle_pct = 14;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values, field extremes, each register and command
    issue(ACT_READ, REG_COMMAND, 8'h00, 8'h00);
    issue(ACT_READ, REG_DATA, 8'hFF, 8'hFF);
    issue(ACT_READ, 8'h00, 8'h00, 8'h00);
    issue(ACT_READ, 8'hFF, 8'hFF, 8'hFF);
    issue(ACT_WRITE, REG_LATCH, 8'hFF, 8'h00);
    issue(ACT_WRITE, REG_TRACK, 8'hFF, 8'h00);
    issue(ACT_WRITE, REG_SECTOR, 8'h00, 8'h00);
    issue(ACT_WRITE, REG_SECTOR, 8'hFF, 8'h00);
    issue(ACT_WRITE, REG_COMMAND, CMD_READ_SECTOR, 8'h00);
    issue(ACT_READ, REG_COMMAND, 8'h00, 8'h00);
    issue(ACT_READ, REG_COMMAND, 8'h00, 8'h00);
    issue(ACT_FILL, 8'h00, 8'hA5, 8'h00);
    issue(ACT_WRITE, REG_COMMAND, CMD_SEEK, 8'h00);
    issue(ACT_FILL, 8'hFF, 8'h5A, 8'hFF);
    issue(ACT_WRITE, REG_DATA, 8'h00, 8'h00);
    issue(ACT_READ, REG_DATA, 8'h00, 8'h00);
    issue(ACT_WRITE, REG_COMMAND, 8'h8F, 8'h00);
    issue(ACT_WRITE, 8'h00, 8'hFF, 8'hFF);
    issue(2'd3, REG_COMMAND, 8'hFF, 8'hFF);
    issue(ACT_READ, REG_TRACK, 8'h00, 8'h00);
    issue(ACT_WRITE, REG_LATCH, 8'h00, 8'h00);
    issue(ACT_WRITE, REG_COMMAND, 8'h00, 8'h00);
    issue(ACT_READ, REG_COMMAND, 8'h00, 8'h00);
    drain();

    // random: sender idles 14%, then 76%, then never
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 76 : 0;
      while (requests_sent < 23 + (ITEM_TARGET * (phase + 1)) / 3) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            // noise: any action, any offset
            issue(2'($urandom_range(0, 3)),
                  $urandom_range(0, 1) ? MAPPED_REGS[$urandom_range(0, 4)]
                                       : 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end
          2: begin
            // command write, biased toward the decoded ones
            case ($urandom_range(0, 3))
              0: cmd = CMD_SEEK;
              1: cmd = CMD_READ_SECTOR;
              2: cmd = CMD_GROUP_READ | 8'($urandom_range(0, 15));
              default: cmd = 8'($urandom_range(0, 255));
            endcase
            issue(ACT_WRITE, REG_COMMAND, cmd, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) issue(ACT_READ, REG_COMMAND, 8'h00, 8'h00);
          end
          3, 4: begin
            // sector request sequence
            issue(ACT_WRITE, REG_LATCH, 8'($urandom_range(0, 255)), 8'h00);
            issue(ACT_WRITE, REG_TRACK, 8'($urandom_range(0, 255)), 8'h00);
            issue(ACT_WRITE, REG_SECTOR, 8'($urandom_range(0, 255)), 8'h00);
            issue(ACT_WRITE, REG_COMMAND, CMD_READ_SECTOR, 8'h00);
            issue(ACT_READ, REG_COMMAND, 8'h00, 8'h00);
            issue(ACT_READ, REG_COMMAND, 8'h00, 8'h00);
          end
          5, 6: begin
            // host fill up to the last byte, which rewinds the pointer
            first = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(230, 255);
            for (int idx = first; idx < 256; idx++)
              issue(ACT_FILL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'(idx));
            if ($urandom_range(0, 1)) issue(ACT_WRITE, REG_COMMAND, CMD_SEEK, 8'h00);
          end
          default: begin
            // data burst; now and then long enough to wrap the buffer
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300)
                                                : $urandom_range(1, 24);
            repeat (count)
              issue($urandom_range(0, 9) < 7 ? ACT_READ : ACT_WRITE, REG_DATA,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end
        endcase
        if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/fcr_pkg.sv
src/fcr_ram.sv
src/fcr_seq.sv
src/floppy_controller_registers.sv
tb/floppy_controller_registers_test.sv
